/* rtl/c3sf_pkg.sv */
// c3sf_pkg: shared types, register map and reset values for the 3x3 filter
// no dependencies; imported by conv3x3_saturating_filter

package c3sf_pkg;

    localparam int PIX_W     = 8;
    localparam int ROW_W     = 12;
    localparam int OCOL_W    = 10;
    localparam int WREG_W    = 11;
    localparam int HREG_W    = 13;
    localparam int KREG_W    = 24;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int MAX_ROWS  = 4096;

    typedef logic [PIX_W-1:0]  pixel_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [OCOL_W-1:0] ocol_t;

    // input op codes
    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    // register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_WIDTH   = 3'd0,
        REG_HEIGHT  = 3'd1,
        REG_KTOP    = 3'd2,
        REG_KMID    = 3'd3,
        REG_KBOTTOM = 3'd4
    } reg_idx_t;

    localparam logic [WREG_W-1:0] WIDTH_RST   = 11'd1024;
    localparam logic [HREG_W-1:0] HEIGHT_RST  = 13'd4096;
    localparam logic [KREG_W-1:0] KTOP_RST    = 24'h000100;
    localparam logic [KREG_W-1:0] KMID_RST    = 24'hFF05FF;
    localparam logic [KREG_W-1:0] KBOTTOM_RST = 24'h00FF00;

endpackage

/* rtl/conv3x3_saturating_filter.sv */
// conv3x3_saturating_filter: 3x3 correlation filter on a raster pixel stream
// two line stores, a 3x3 window, product and sum stages; uses c3sf_pkg
//
//   channel   dir  handshake           word
//   s_        in   s_valid / s_ready   s_op, s_pixel
//   m_        out  m_valid / m_ready   m_pixel_out, m_out_row, m_out_col, m_last_of_frame
//   apb       in   psel/penable/pready paddr, pwdata, prdata (5 registers at 4*i)
//
// one word per clock sustained while m_ is not stalled; the line store read, the window
// update with the nine products, and the sum with clamp are three register stages; the
// first is loaded at the edge that takes the word, so its result reaches m_ through the
// product and output registers (plus the one row and one pixel of frame lag)
// s_ready drops only when all three stages are full and m_ is stalled
// reset (aresetn low, synchronous) clears counters, valid bits and the window; the
// line stores are not cleared and need no clearing pass after reset

module conv3x3_saturating_filter #(
    parameter int MAX_WIDTH = 1024,
    parameter int COEF_BITS = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // pixel input
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_op,
    input  c3sf_pkg::pixel_t           s_pixel,
    // result output
    output logic                       m_valid,
    input  logic                       m_ready,
    output c3sf_pkg::pixel_t           m_pixel_out,
    output c3sf_pkg::row_t             m_out_row,
    output c3sf_pkg::ocol_t            m_out_col,
    output logic                       m_last_of_frame,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [c3sf_pkg::APB_AW-1:0] paddr,
    input  logic [c3sf_pkg::APB_DW-1:0] pwdata,
    output logic [c3sf_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    import c3sf_pkg::*;

    // column counter / address width and a width wide enough for compares
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > WREG_W) ? CW + 1 : WREG_W;
    // coefficient unpacking: fields above the register read as zero
    localparam int KW = 3 * COEF_BITS;
    // product and sum widths
    localparam int PW = PIX_W + 1 + COEF_BITS;
    localparam int SW = PW + 4;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [WREG_W-1:0] width_reg;
    logic [HREG_W-1:0] height_reg;
    logic [KREG_W-1:0] ktop_reg;
    logic [KREG_W-1:0] kmid_reg;
    logic [KREG_W-1:0] kbottom_reg;

    reg_idx_t reg_sel;
    logic     cfg_wr;
    logic     cfg_restart;

    assign pready      = 1'b1;
    assign reg_sel     = reg_idx_t'(paddr[4:2]);
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign cfg_restart = cfg_wr && (reg_sel == REG_WIDTH || reg_sel == REG_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WIDTH_RST;
            height_reg  <= HEIGHT_RST;
            ktop_reg    <= KTOP_RST;
            kmid_reg    <= KMID_RST;
            kbottom_reg <= KBOTTOM_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_WIDTH:   width_reg   <= pwdata[WREG_W-1:0];
                REG_HEIGHT:  height_reg  <= pwdata[HREG_W-1:0];
                REG_KTOP:    ktop_reg    <= pwdata[KREG_W-1:0];
                REG_KMID:    kmid_reg    <= pwdata[KREG_W-1:0];
                REG_KBOTTOM: kbottom_reg <= pwdata[KREG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_WIDTH:   prdata = APB_DW'(width_reg);
            REG_HEIGHT:  prdata = APB_DW'(height_reg);
            REG_KTOP:    prdata = APB_DW'(ktop_reg);
            REG_KMID:    prdata = APB_DW'(kmid_reg);
            REG_KBOTTOM: prdata = APB_DW'(kbottom_reg);
            default:     prdata = '0;
        endcase
    end

    // effective frame size, saturated to the supported range
    logic [WW-1:0]     w_eff;
    logic [WW-1:0]     w_m1;
    logic [HREG_W-1:0] h_eff;
    row_t              h_m1;

    always_comb begin
        w_eff = WW'(width_reg);
        if (w_eff == '0) begin
            w_eff = WW'(1);
        end else if (w_eff > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end
        h_eff = height_reg;
        if (h_eff == '0) begin
            h_eff = HREG_W'(1);
        end else if (h_eff > HREG_W'(MAX_ROWS)) begin
            h_eff = HREG_W'(MAX_ROWS);
        end
    end

    assign w_m1 = w_eff - WW'(1);
    assign h_m1 = ROW_W'(h_eff - HREG_W'(1));

    // ------------------------------------------------------------------
    // stage handshakes: s1 = line store read, s2 = products, out = result
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic m_valid_reg;
    logic out_adv;
    logic s2_adv;
    logic s1_move;
    logic s_accept;

    assign out_adv  = !m_valid_reg || m_ready;
    assign s2_adv   = !s2_valid_reg || out_adv;
    assign s1_move  = s1_valid_reg && s2_adv;
    assign s_ready  = !s1_valid_reg || s1_move;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    // ------------------------------------------------------------------
    // frame counters, evaluated on the incoming word
    // ------------------------------------------------------------------
    row_t          irow_reg;
    logic [CW-1:0] icol_reg;
    row_t          orow_reg;
    logic [CW-1:0] ocol_reg;
    logic          draining_reg;

    row_t          irow_next;
    logic [CW-1:0] icol_next;
    row_t          orow_next;
    logic [CW-1:0] ocol_next;
    logic          draining_next;

    logic          proc;       // word moves the pipeline (flush outside drain is dropped)
    logic          dr;
    row_t          irow;
    logic [CW-1:0] icol;
    row_t          orow;
    logic [CW-1:0] ocol;
    logic [WW-1:0] icol_w;
    logic [WW-1:0] ocol_w;
    logic [WW-1:0] icol_inc;
    logic [WW-1:0] ocol_inc;
    pixel_t        pix_eff;
    logic          due;
    logic          last_in;
    logic          border;
    logic          last_out;

    always_comb begin
        proc    = (s_op == OP_PIXEL) || draining_reg;
        // a pixel during drain drops what is pending and opens a new frame
        dr      = draining_reg && (s_op == OP_FLUSH);
        irow    = dr ? irow_reg : (draining_reg ? '0 : irow_reg);
        icol    = dr ? icol_reg : (draining_reg ? '0 : icol_reg);
        orow    = dr ? orow_reg : (draining_reg ? '0 : orow_reg);
        ocol    = dr ? ocol_reg : (draining_reg ? '0 : ocol_reg);
        pix_eff = (s_op == OP_FLUSH) ? '0 : s_pixel;
        icol_w  = WW'(icol);
        ocol_w  = WW'(ocol);

        // one row plus one pixel received
        due     = dr || (irow >= ROW_W'(2)) || (irow == ROW_W'(1) && icol != '0);
        last_in = !dr && irow == h_m1 && icol_w == w_m1;

        border   = orow == '0 || orow >= h_m1 || ocol == '0 || ocol_w >= w_m1;
        last_out = orow == h_m1 && ocol_w == w_m1;

        icol_inc = icol_w + WW'(1);
        ocol_inc = ocol_w + WW'(1);

        irow_next     = irow;
        icol_next     = icol;
        orow_next     = orow;
        ocol_next     = ocol;
        draining_next = dr;

        if (last_in) begin
            irow_next     = '0;
            icol_next     = '0;
            draining_next = 1'b1;
        end else if (icol_inc >= w_eff) begin
            icol_next = '0;
            irow_next = irow + ROW_W'(1);
        end else begin
            icol_next = icol_inc[CW-1:0];
        end

        if (due) begin
            if (last_out) begin
                irow_next     = '0;
                icol_next     = '0;
                orow_next     = '0;
                ocol_next     = '0;
                draining_next = 1'b0;
            end else if (ocol_inc >= w_eff) begin
                ocol_next = '0;
                orow_next = orow + ROW_W'(1);
            end else begin
                ocol_next = ocol_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_restart) begin
            irow_reg     <= '0;
            icol_reg     <= '0;
            orow_reg     <= '0;
            ocol_reg     <= '0;
            draining_reg <= 1'b0;
        end else if (s_accept && proc) begin
            irow_reg     <= irow_next;
            icol_reg     <= icol_next;
            orow_reg     <= orow_next;
            ocol_reg     <= ocol_next;
            draining_reg <= draining_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: line store read with bypass of the write leaving this stage
    // ------------------------------------------------------------------
    pixel_t store_a_mem [MAX_WIDTH];
    pixel_t store_b_mem [MAX_WIDTH];

    logic [CW-1:0] s1_addr_reg;
    pixel_t        s1_pix_reg;
    logic          s1_due_reg;
    logic          s1_border_reg;
    logic          s1_last_reg;
    row_t          s1_row_reg;
    ocol_t         s1_col_reg;
    pixel_t        rd_a_reg;
    pixel_t        rd_b_reg;
    logic          fwd_hit_reg;
    pixel_t        fwd_a_reg;
    pixel_t        fwd_b_reg;
    pixel_t        a_eff;
    pixel_t        b_eff;

    assign a_eff = fwd_hit_reg ? fwd_a_reg : rd_a_reg;
    assign b_eff = fwd_hit_reg ? fwd_b_reg : rd_b_reg;

    // row above moves to the second line store, new pixel into the first
    always_ff @(posedge aclk) begin
        if (s1_move) begin
            store_a_mem[s1_addr_reg] <= s1_pix_reg;
            store_b_mem[s1_addr_reg] <= a_eff;
        end
        if (s_accept && proc) begin
            rd_a_reg <= store_a_mem[icol];
            rd_b_reg <= store_b_mem[icol];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_accept && proc;
            end
            if (s_accept && proc) begin
                fwd_hit_reg <= s1_move && (s1_addr_reg == icol);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && proc) begin
            s1_addr_reg   <= icol;
            s1_pix_reg    <= pix_eff;
            s1_due_reg    <= due;
            s1_border_reg <= border;
            s1_last_reg   <= last_out;
            s1_row_reg    <= orow;
            s1_col_reg    <= ocol_w[OCOL_W-1:0];
            fwd_a_reg     <= s1_pix_reg;
            fwd_b_reg     <= a_eff;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: window shift and the nine products
    // ------------------------------------------------------------------
    pixel_t                 win_reg  [9];
    pixel_t                 win_next [9];
    logic [KW+KREG_W-1:0]   kext     [3];
    logic signed [COEF_BITS-1:0] coef [9];
    logic signed [PW-1:0]   prod_next [9];
    logic signed [PW-1:0]   prod_reg  [9];
    logic                   s2_border_reg;
    logic                   s2_last_reg;
    row_t                   s2_row_reg;
    ocol_t                  s2_col_reg;
    pixel_t                 s2_center_reg;

    assign kext[0] = {{KW{1'b0}}, ktop_reg};
    assign kext[1] = {{KW{1'b0}}, kmid_reg};
    assign kext[2] = {{KW{1'b0}}, kbottom_reg};

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_next[r*3]     = win_reg[r*3+1];
            win_next[r*3+1]   = win_reg[r*3+2];
            for (int c = 0; c < 3; c++) begin
                coef[r*3+c] = $signed(kext[r][c*COEF_BITS +: COEF_BITS]);
            end
        end
        win_next[2] = b_eff;
        win_next[5] = a_eff;
        win_next[8] = s1_pix_reg;
        for (int i = 0; i < 9; i++) begin
            prod_next[i] = PW'($signed({1'b0, win_next[i]})) * PW'(coef[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (s1_move) begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_adv) begin
            s2_valid_reg <= s1_move && s1_due_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move && s2_adv) begin
            prod_reg      <= prod_next;
            s2_border_reg <= s1_border_reg;
            s2_last_reg   <= s1_last_reg;
            s2_row_reg    <= s1_row_reg;
            s2_col_reg    <= s1_col_reg;
            s2_center_reg <= win_next[4];
        end
    end

    // ------------------------------------------------------------------
    // stage 3: sum, clamp to 0..255, border bypass, output register
    // ------------------------------------------------------------------
    logic signed [SW-1:0] sum;
    pixel_t               clamped;
    pixel_t               m_pixel_reg;
    row_t                 m_row_reg;
    ocol_t                m_col_reg;
    logic                 m_last_reg;

    always_comb begin
        sum = '0;
        for (int i = 0; i < 9; i++) begin
            sum = sum + SW'(prod_reg[i]);
        end
        if (sum < 0) begin
            clamped = '0;
        end else if (sum > SW'(255)) begin
            clamped = '1;
        end else begin
            clamped = sum[PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && s2_valid_reg) begin
            m_pixel_reg <= s2_border_reg ? s2_center_reg : clamped;
            m_row_reg   <= s2_row_reg;
            m_col_reg   <= s2_col_reg;
            m_last_reg  <= s2_last_reg;
        end
    end

    assign m_pixel_out     = m_pixel_reg;
    assign m_out_row       = m_row_reg;
    assign m_out_col       = m_col_reg;
    assign m_last_of_frame = m_last_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // input only stalls behind a full line store stage
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> s1_valid_reg)
        else $error("s_ready low with empty first stage");

    // bypass only taken when the previous word left stage 1 at the read edge
    a_fwd_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(fwd_hit_reg) |-> $past(s1_valid_reg))
        else $error("line store bypass without a pending write");

    // the drain never runs past the second input row
    a_drain_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        draining_reg |-> irow_reg <= ROW_W'(1))
        else $error("input row counter ran away while draining");

endmodule
